// File: sv/stp_pkg.sv
package stp_pkg;

  localparam int RangeW  = 16;
  localparam int AngleW  = 16;
  localparam int CoefW   = 16;
  localparam int OffsetW = 21;
  localparam int PointW  = 22;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 21;
  localparam int Stages  = 15;
  localparam int StageW  = 4;
  // CORDIC datapath: range * 2^16 with growth headroom
  localparam int CordW   = 36;
  localparam int ZW      = 17;
  localparam int InvGain = 19899;
  localparam int QueueDepth = 2;
  localparam int PointMax = 2097151;
  localparam int PointMin = -2097152;

  localparam logic [CfgIdxW-1:0] RegRangeMin   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRangeMax   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAngleStart = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAngleStep  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegYawCos     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegYawSin     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegOffsetX    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegOffsetY    = 3'd7;

  // accepted sample handed from front to back
  typedef struct packed {
    logic [RangeW-1:0] range;
    logic [AngleW-1:0] angle;
  } beam_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_GAIN, ST_YAW_A, ST_YAW_B, ST_ROUND, ST_DONE
  } back_state_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [StageW-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      4'd0: v = 17'sd8192;
      4'd1: v = 17'sd4836;
      4'd2: v = 17'sd2555;
      4'd3: v = 17'sd1297;
      4'd4: v = 17'sd651;
      4'd5: v = 17'sd326;
      4'd6: v = 17'sd163;
      4'd7: v = 17'sd81;
      4'd8: v = 17'sd41;
      4'd9: v = 17'sd20;
      4'd10: v = 17'sd10;
      4'd11: v = 17'sd5;
      4'd12: v = 17'sd3;
      4'd13: v = 17'sd1;
      4'd14: v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/stp_front.sv
// Range gate and beam angle tracking; pushes accepted in-gate beams into the queue.
module stp_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [stp_pkg::RangeW-1:0] range_mm,
  input  logic first_of_scan,
  input  logic [stp_pkg::RangeW-1:0] gate_lo,
  input  logic [stp_pkg::RangeW-1:0] gate_hi,
  input  logic [stp_pkg::AngleW-1:0] angle_start,
  input  logic [stp_pkg::AngleW-1:0] angle_step,
  output logic q_push,
  input  logic q_full,
  output stp_pkg::beam_t q_data
);
  logic [stp_pkg::AngleW-1:0] beam_angle;
  logic [stp_pkg::AngleW-1:0] cur_angle;
  logic take;
  logic in_gate;

  assign full = q_full;
  assign take = push && !q_full;
  assign cur_angle = first_of_scan ? angle_start : beam_angle;
  assign in_gate = (range_mm >= gate_lo) && (range_mm <= gate_hi);
  assign q_push = take && in_gate;
  assign q_data.range = range_mm;
  assign q_data.angle = cur_angle;

  // angle advances on every accepted sample, in gate or not
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle <= '0;
    end else if (take) begin
      beam_angle <= cur_angle + angle_step;
    end
  end
endmodule

// File: sv/stp_queue.sv
// Small register queue between front and back.
module stp_queue #(
  parameter int Depth = stp_pkg::QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  output logic full,
  input  stp_pkg::beam_t wdata,
  input  logic rd,
  output logic empty,
  output stp_pkg::beam_t rdata
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  stp_pkg::beam_t mem [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic [PtrW:0] count;

  assign full = (count == (PtrW+1)'(Depth));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers wrap at Depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PtrW+1)'(wr && !full) - (PtrW+1)'(rd && !empty);
    end
  end
endmodule

// File: sv/stp_back.sv
// Iterative CORDIC, gain, yaw rotation, rounding with offset and saturation; one-entry output register.
module stp_back (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  output logic q_pop,
  input  stp_pkg::beam_t q_data,
  input  logic [stp_pkg::CoefW-1:0] yaw_cos,
  input  logic [stp_pkg::CoefW-1:0] yaw_sin,
  input  logic [stp_pkg::OffsetW-1:0] offset_x,
  input  logic [stp_pkg::OffsetW-1:0] offset_y,
  output logic empty,
  input  logic pop,
  output logic [stp_pkg::PointW-1:0] point_x,
  output logic [stp_pkg::PointW-1:0] point_y
);
  localparam int CW = stp_pkg::CordW;
  localparam int PW = CW + 16;   // product width

  stp_pkg::back_state_t state, state_next;
  logic signed [CW-1:0] x, y;
  logic signed [stp_pkg::ZW-1:0] z;
  logic [stp_pkg::StageW-1:0] stage;
  logic signed [PW-1:0] pa, pb;
  logic signed [PW-1:0] sx, sy;
  logic out_valid;

  logic [stp_pkg::AngleW-1:0] a;
  logic [stp_pkg::AngleW-1:0] z_init;
  logic quad_flip;
  logic signed [CW-1:0] r_ext;
  logic signed [CW-1:0] dx, dy;
  logic signed [PW-1:0] px_full, py_full;
  logic signed [PW-1:0] rx, ry;

  assign a = q_data.angle;
  assign quad_flip = (a >= 16'd16384) && (a < 16'd49152);
  // folded angle as a 16-bit two's complement value; a half turn is taken out on a flip
  assign z_init = quad_flip ? (a ^ 16'h8000) : a;
  assign r_ext = CW'({q_data.range, 16'h0000});
  assign dx = y >>> stage;
  assign dy = x >>> stage;

  assign px_full = sx >>> 15;
  assign py_full = sy >>> 15;
  assign rx = ((px_full + PW'(32768)) >>> 16) + PW'($signed(offset_x));
  assign ry = ((py_full + PW'(32768)) >>> 16) + PW'($signed(offset_y));

  assign empty = !out_valid;
  assign q_pop = (state == stp_pkg::ST_IDLE) && !q_empty;

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      stp_pkg::ST_IDLE:   if (!q_empty) state_next = stp_pkg::ST_CORDIC;
      stp_pkg::ST_CORDIC: if (stage == stp_pkg::StageW'(stp_pkg::Stages - 1))
                            state_next = stp_pkg::ST_GAIN;
      stp_pkg::ST_GAIN:   state_next = stp_pkg::ST_YAW_A;
      stp_pkg::ST_YAW_A:  state_next = stp_pkg::ST_YAW_B;
      stp_pkg::ST_YAW_B:  state_next = stp_pkg::ST_ROUND;
      stp_pkg::ST_ROUND:  if (!out_valid || pop) state_next = stp_pkg::ST_DONE;
      stp_pkg::ST_DONE:   state_next = stp_pkg::ST_IDLE;
      default:            state_next = stp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stp_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == stp_pkg::ST_ROUND && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath: gain and yaw products each take a registered multiply step
  always_ff @(posedge clk) begin
    unique case (state)
      stp_pkg::ST_IDLE: begin
        stage <= '0;
        y <= '0;
        x <= quad_flip ? -r_ext : r_ext;
        z <= {z_init[stp_pkg::AngleW-1], z_init};
      end
      stp_pkg::ST_CORDIC: begin
        if (z >= 0) begin
          x <= x - dx; y <= y + dy; z <= z - stp_pkg::atan_lut(stage);
        end else begin
          x <= x + dx; y <= y - dy; z <= z + stp_pkg::atan_lut(stage);
        end
        stage <= stage + 1'b1;
      end
      stp_pkg::ST_GAIN: begin
        x <= CW'((PW'(x) * PW'(stp_pkg::InvGain)) >>> 15);
        y <= CW'((PW'(y) * PW'(stp_pkg::InvGain)) >>> 15);
      end
      stp_pkg::ST_YAW_A: begin
        pa <= PW'(x) * PW'($signed(yaw_cos));
        pb <= PW'(y) * PW'($signed(yaw_sin));
        sy <= PW'(x) * PW'($signed(yaw_sin));
        sx <= PW'(y) * PW'($signed(yaw_cos));
      end
      stp_pkg::ST_YAW_B: begin
        sx <= pa - pb;
        sy <= sy + sx;
      end
      stp_pkg::ST_ROUND: begin
        if (!out_valid || pop) begin
          if (rx > PW'(stp_pkg::PointMax)) point_x <= stp_pkg::PointW'(stp_pkg::PointMax);
          else if (rx < PW'(stp_pkg::PointMin)) point_x <= stp_pkg::PointW'(stp_pkg::PointMin);
          else point_x <= rx[stp_pkg::PointW-1:0];
          if (ry > PW'(stp_pkg::PointMax)) point_y <= stp_pkg::PointW'(stp_pkg::PointMax);
          else if (ry < PW'(stp_pkg::PointMin)) point_y <= stp_pkg::PointW'(stp_pkg::PointMin);
          else point_y <= ry[stp_pkg::PointW-1:0];
        end
      end
      default: ;
    endcase
  end
endmodule

// File: sv/scan_to_points_unit.sv
// scan_to_points_unit: projects laser range samples to base-frame points.
// Input queue side: range_mm and first_of_scan are taken when push is high
// and full is low. first_of_scan loads the beam angle from angle_start; the
// angle advances by angle_step after every sample, gated or not.
// Output queue side: point_x/point_y are valid while empty is low and are
// consumed when pop is high. Samples outside the inclusive range gate give
// no point.
// Path from the accepting edge to the ports with an idle back end: queue
// read, 15-step iterative CORDIC, gain, two yaw multiply steps and rounding.
// The back end takes a new sample only after it has finished the last; the
// front end and its two-entry queue absorb short bursts and take gated-out
// samples at once. A stalled output holds its point; the back end then
// waits and the queue fills, raising full.
// Reset (rst, synchronous) restores register defaults, clears the angle and
// empties all queues. Configuration writes (cfg_we, cfg_idx, cfg_data)
// take effect at the next edge and should be done while idle.
module scan_to_points_unit (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [stp_pkg::RangeW-1:0] range_mm,
  input  logic first_of_scan,
  output logic empty,
  input  logic pop,
  output logic [stp_pkg::PointW-1:0] point_x,
  output logic [stp_pkg::PointW-1:0] point_y,
  input  logic cfg_we,
  input  logic [stp_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [stp_pkg::CfgDataW-1:0] cfg_data
);
  logic [15:0] gate_lo, gate_hi, angle_start, angle_step, yaw_cos, yaw_sin;
  logic [stp_pkg::OffsetW-1:0] offset_x, offset_y;
  logic q_push, q_full, q_pop, q_empty;
  stp_pkg::beam_t q_wdata, q_rdata;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_lo <= '0; gate_hi <= 16'hFFFF; angle_start <= '0; angle_step <= '0;
      yaw_cos <= 16'h7FFF; yaw_sin <= '0; offset_x <= '0; offset_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        stp_pkg::RegRangeMin:   gate_lo <= cfg_data[15:0];
        stp_pkg::RegRangeMax:   gate_hi <= cfg_data[15:0];
        stp_pkg::RegAngleStart: angle_start <= cfg_data[15:0];
        stp_pkg::RegAngleStep:  angle_step <= cfg_data[15:0];
        stp_pkg::RegYawCos:     yaw_cos <= cfg_data[15:0];
        stp_pkg::RegYawSin:     yaw_sin <= cfg_data[15:0];
        stp_pkg::RegOffsetX:    offset_x <= cfg_data;
        stp_pkg::RegOffsetY:    offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  stp_front u_front (
    .clk, .rst, .push, .full, .range_mm, .first_of_scan,
    .gate_lo, .gate_hi, .angle_start, .angle_step,
    .q_push, .q_full, .q_data(q_wdata)
  );

  stp_queue #(.Depth(stp_pkg::QueueDepth)) u_queue (
    .clk, .rst, .wr(q_push), .full(q_full), .wdata(q_wdata),
    .rd(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  stp_back u_back (
    .clk, .rst, .q_empty, .q_pop, .q_data(q_rdata),
    .yaw_cos, .yaw_sin, .offset_x, .offset_y,
    .empty, .pop, .point_x, .point_y
  );
endmodule
